FILE: rtl/iir_df2t_pkg.sv
// Constants shared by the DF-II transposed IIR filter: coefficient format,
// delay stage width and configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package iir_df2t_pkg;

  localparam int unsigned COEF_W    = 18;  // Q3.14 coefficients
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned DELAY_W   = 40;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned CFG_IDX_W = 4;   // room for indexes beyond the list
  localparam int unsigned ORDER_W   = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_B0    = CFG_IDX_W'(1);

  // Coefficient store slots: b0..b3 then a1..a3
  localparam int unsigned NUM_COEF  = NUM_REGS - 1;
  localparam logic [2:0]  SLOT_B0   = 3'd0;
  localparam logic [2:0]  SLOT_B1   = 3'd1;
  localparam logic [2:0]  SLOT_A1   = 3'd4;

  localparam logic [ORDER_W-1:0]        ORDER_RESET = 2'd2;
  localparam logic signed [COEF_W-1:0]  B0_RESET    = 18'sd16384;

endpackage

FILE: rtl/iir_filter_df2t_top.sv
// Direct form II transposed IIR filter, orders 0 to MAX_ORDER, with one
// shared multiplier and a small sequencer. Depends on iir_df2t_pkg.
`timescale 1ns / 1ps

//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------
//  in      | in_valid_i / in_stall_o   | sample_in_i
//  out     | out_valid_o / out_stall_i | sample_out_o, saturated_o
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each sample runs from accept to the output register through the b0 product,
// accumulate and round steps, then for each of the n stages in use (n the order
// clamped to MAX_ORDER) feedforward product, accumulate while the feedback
// product runs, and subtract and saturate; a last step loads the result.
// in_stall_o is high while a sample is in work, so the next accept comes in the
// cycle after the load at the earliest.
// A result waiting in the output register does not block the next accept, only
// the hand-off of the next result: the sequencer holds in S_OUT meanwhile.
// Reset clears the delay line and loads the register reset values.

module iir_filter_df2t_top #(
  parameter int unsigned MAX_ORDER    = 3,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]           sample_in_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]           sample_out_o,
  output logic                                     saturated_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [iir_df2t_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [iir_df2t_pkg::COEF_W-1:0]          cfg_data_i
);

  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned CW     = iir_df2t_pkg::COEF_W;
  localparam int unsigned DW     = iir_df2t_pkg::DELAY_W;
  localparam int unsigned FB     = iir_df2t_pkg::FRAC_BITS;
  localparam int unsigned PROD_W = CW + SW;
  localparam int unsigned ACC_W  = ((DW > PROD_W) ? DW : PROD_W) + 2;
  localparam int unsigned JW     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int unsigned NW     = $clog2(MAX_ORDER + 1);
  localparam int unsigned OW     = iir_df2t_pkg::ORDER_W;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (FB - 1));
  localparam logic signed [ACC_W-1:0] Y_MAX    = ACC_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] Y_MIN    = ACC_W'(-(64'sd1 <<< (SW - 1)));
  localparam logic signed [ACC_W-1:0] D_MAX    = ACC_W'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] D_MIN    = ACC_W'(-(64'sd1 <<< (DW - 1)));

  typedef enum logic [2:0] {
    S_IDLE,
    S_MB0,   // b0 * x
    S_AB0,   // acc = b0*x + z0
    S_RND,   // round and clip y
    S_MB,    // b[j+1] * x
    S_AB,    // acc = b[j+1]*x + z[j+1], start a[j+1] * y
    S_AA,    // z[j] = sat(acc - a[j+1]*y)
    S_OUT
  } state_e;

  state_e                    state_q, state_d;
  logic [OW-1:0]             order_q;
  logic signed [CW-1:0]      coef_q [iir_df2t_pkg::NUM_COEF];
  logic signed [DW-1:0]      z_q [MAX_ORDER];
  logic [NW-1:0]             n_q, n_d;
  logic [JW-1:0]             j_q;
  logic                      out_valid_q;
  logic signed [SW-1:0]      sample_out_q;
  logic                      sat_q;

  // Datapath registers, no reset
  logic signed [SW-1:0]      x_q, y_q, y_d;
  logic                      clip_q, clip_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;

  logic [2:0]                coef_idx;
  logic                      sel_y;
  logic signed [CW-1:0]      mul_coef;
  logic signed [SW-1:0]      mul_smp;
  logic signed [ACC_W-1:0]   prod_ext, z_next, diff, y_wide, rnd;
  logic signed [DW-1:0]      z_new;
  logic [NW:0]               j_ext, j_inc, n_ext;
  logic                      out_load;

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign saturated_o  = sat_q;
  assign cfg_ready_o  = 1'b1;

  assign j_ext = (NW + 1)'(j_q);
  assign j_inc = j_ext + (NW + 1)'(1);
  assign n_ext = (NW + 1)'(n_q);

  // Clamp the order register to the stages built
  assign n_d = (order_q > OW'(MAX_ORDER)) ? NW'(MAX_ORDER) : NW'(order_q);

  // Shared multiplier operand select
  always_comb begin
    coef_idx = iir_df2t_pkg::SLOT_B0;
    sel_y    = 1'b0;
    case (state_q)
      S_MB:    coef_idx = 3'(j_q) + iir_df2t_pkg::SLOT_B1;
      S_AB: begin
        coef_idx = 3'(j_q) + iir_df2t_pkg::SLOT_A1;
        sel_y    = 1'b1;
      end
      default: coef_idx = iir_df2t_pkg::SLOT_B0;
    endcase
  end

  assign mul_coef = coef_q[coef_idx];
  assign mul_smp  = sel_y ? y_q : x_q;
  assign prod_d   = PROD_W'(mul_coef) * PROD_W'(mul_smp);
  assign prod_ext = ACC_W'(prod_q);

  // Next delay stage into the sum, zero past the order in use
  always_comb begin
    z_next = '0;
    for (int k = 0; k < MAX_ORDER; k++) begin
      if (j_inc == (NW + 1)'(k) && j_inc < n_ext) begin
        z_next = ACC_W'(z_q[k]);
      end
    end
  end

  always_comb begin
    acc_d = acc_q;
    case (state_q)
      S_AB0:   acc_d = prod_ext + ((n_q != '0) ? ACC_W'(z_q[0]) : '0);
      S_AB:    acc_d = prod_ext + z_next;
      default: acc_d = acc_q;
    endcase
  end

  // Round half up, then clip to the sample range
  assign rnd    = acc_q + RND_HALF;
  assign y_wide = rnd >>> FB;
  always_comb begin
    clip_d = 1'b0;
    y_d    = y_wide[SW-1:0];
    if (y_wide > Y_MAX) begin
      y_d    = Y_MAX[SW-1:0];
      clip_d = 1'b1;
    end else if (y_wide < Y_MIN) begin
      y_d    = Y_MIN[SW-1:0];
      clip_d = 1'b1;
    end
  end

  // New delay stage value, saturated to the stage width
  assign diff = acc_q - prod_ext;
  always_comb begin
    z_new = diff[DW-1:0];
    if (diff > D_MAX) begin
      z_new = D_MAX[DW-1:0];
    end else if (diff < D_MIN) begin
      z_new = D_MIN[DW-1:0];
    end
  end

  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_MB0;
      S_MB0:   state_d = S_AB0;
      S_AB0:   state_d = S_RND;
      S_RND:   state_d = (n_q == '0) ? S_OUT : S_MB;
      S_MB:    state_d = S_AB;
      S_AB:    state_d = S_AA;
      S_AA:    state_d = (j_inc < n_ext) ? S_MB : S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      x_q <= sample_in_i;
    end
    if (state_q == S_MB0 || state_q == S_MB || state_q == S_AB) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
    if (state_q == S_RND) begin
      y_q    <= y_d;
      clip_q <= clip_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      order_q      <= iir_df2t_pkg::ORDER_RESET;
      for (int i = 0; i < iir_df2t_pkg::NUM_COEF; i++) begin
        coef_q[i] <= (i == int'(iir_df2t_pkg::SLOT_B0)) ? iir_df2t_pkg::B0_RESET : '0;
      end
      for (int k = 0; k < MAX_ORDER; k++) begin
        z_q[k] <= '0;
      end
      n_q          <= '0;
      j_q          <= '0;
      out_valid_q  <= 1'b0;
      sample_out_q <= '0;
      sat_q        <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        if (cfg_index_i == iir_df2t_pkg::REG_ORDER) begin
          order_q <= cfg_data_i[OW-1:0];
        end else if (cfg_index_i < iir_df2t_pkg::CFG_IDX_W'(iir_df2t_pkg::NUM_REGS)) begin
          coef_q[3'(cfg_index_i - iir_df2t_pkg::REG_B0)] <= cfg_data_i;
        end
      end

      if (state_q == S_IDLE && in_valid_i) begin
        n_q <= n_d;
      end

      case (state_q)
        S_RND: begin
          j_q <= '0;
          // Drop stages past the order in use
          for (int k = 0; k < MAX_ORDER; k++) begin
            if ((NW + 1)'(k) >= n_ext) begin
              z_q[k] <= '0;
            end
          end
        end
        S_AA: begin
          for (int k = 0; k < MAX_ORDER; k++) begin
            if (j_q == JW'(k)) begin
              z_q[k] <= z_new;
            end
          end
          if (j_inc < n_ext) begin
            j_q <= JW'(j_inc);
          end
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_q  <= 1'b1;
        sample_out_q <= y_q;
        sat_q        <= clip_q;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted a sample but did not go busy");

  a_tap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MB || state_q == S_AB || state_q == S_AA) |-> (j_ext < n_ext))
    else $error("tap counter beyond order in use");

  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result beat without a finished sample");

  a_clip_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && sat_q) |->
      (sample_out_q == {1'b0, {(SW-1){1'b1}}} || sample_out_q == {1'b1, {(SW-1){1'b0}}}))
    else $error("saturated flag set but sample not at a rail");
`endif

endmodule

FILE: verif/tb.sv
// Self-checking bench for iir_filter_df2t_top: directed and random samples across
// several filter orders and coefficient sets, checked against an internal model.
// Depends on iir_df2t_pkg and the filter top level.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CFG_IDX_W = iir_df2t_pkg::CFG_IDX_W;
  localparam int unsigned NUM_REGS  = iir_df2t_pkg::NUM_REGS;
  localparam int unsigned COEF_W    = iir_df2t_pkg::COEF_W;
  localparam int unsigned FRAC_BITS = iir_df2t_pkg::FRAC_BITS;
  localparam int unsigned DELAY_W   = iir_df2t_pkg::DELAY_W;
  localparam int unsigned ORDER_W   = iir_df2t_pkg::ORDER_W;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned MAX_ORDER   = 3;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam int unsigned SETTLE      = 20;  // wait after the queues empty

  localparam logic [CFG_IDX_W-1:0] REG_ORDER = iir_df2t_pkg::REG_ORDER;
  localparam logic [CFG_IDX_W-1:0] REG_B0 = iir_df2t_pkg::REG_B0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_B2 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_B3 = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_A1 = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_A2 = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_A3 = CFG_IDX_W'(7);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_BITS);
  localparam logic [COEF_W-1:0] COEF_HALF = COEF_W'(1 << (FRAC_BITS - 1));

  localparam longint DELAY_MAX = (longint'(1) << (DELAY_W - 1)) - 1;
  localparam longint DELAY_MIN = -(longint'(1) << (DELAY_W - 1));
  localparam longint Y_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint Y_MIN = -(longint'(1) << (SAMPLE_W - 1));

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip;
  } filt_result_t;

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic signed [SAMPLE_W-1:0]  sample_in_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0]  sample_out_o;
  logic                        saturated_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i = '0;
  logic [COEF_W-1:0]           cfg_data_i = '0;

  iir_filter_df2t_top #(
    .MAX_ORDER   (MAX_ORDER),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o),
    .saturated_o (saturated_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Filter shadow: configuration and delay line
  logic [ORDER_W-1:0]       order_q = iir_df2t_pkg::ORDER_RESET;
  logic signed [COEF_W-1:0] coef_b[4] = '{iir_df2t_pkg::B0_RESET, '0, '0, '0};
  logic signed [COEF_W-1:0] coef_a[4] = '{'0, '0, '0, '0};
  longint                   delay_z[MAX_ORDER] = '{0, 0, 0};

  logic signed [SAMPLE_W-1:0] sample_queue[$];
  filt_result_t               expected_out[$];
  int                         error_count = 0;
  bit                         idle_on = 1'b1;
  int                         gap_left = 0;
  int                         stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= 100)
      $display("%0t: %0s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [COEF_W-1:0] data);
    case (idx)
      REG_ORDER: order_q   = data[ORDER_W-1:0];
      REG_B0:    coef_b[0] = data;
      REG_B1:    coef_b[1] = data;
      REG_B2:    coef_b[2] = data;
      REG_B3:    coef_b[3] = data;
      REG_A1:    coef_a[1] = data;
      REG_A2:    coef_a[2] = data;
      REG_A3:    coef_a[3] = data;
      default: ;  // beyond the register list: drop
    endcase
  endfunction

  function automatic void filter_step(input logic signed [SAMPLE_W-1:0] x,
                                      output logic signed [SAMPLE_W-1:0] y_o,
                                      output logic clip_o);
    longint xs;
    longint acc;
    longint y;
    longint nxt;
    int     n;
    xs = x;
    n = (order_q > MAX_ORDER) ? MAX_ORDER : order_q;
    acc = longint'(coef_b[0]) * xs;
    if (n > 0) acc += delay_z[0];
    // Round half up, then clip to the sample range
    y = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    clip_o = 1'b0;
    if (y > Y_MAX) begin
      y = Y_MAX;
      clip_o = 1'b1;
    end
    if (y < Y_MIN) begin
      y = Y_MIN;
      clip_o = 1'b1;
    end
    for (int j = 0; j < n; j++) begin
      nxt = longint'(coef_b[j+1]) * xs - longint'(coef_a[j+1]) * y;
      if (j + 1 < n) nxt += delay_z[j+1];
      if (nxt > DELAY_MAX) nxt = DELAY_MAX;
      if (nxt < DELAY_MIN) nxt = DELAY_MIN;
      delay_z[j] = nxt;
    end
    for (int j = n; j < MAX_ORDER; j++) delay_z[j] = 0;
    y_o = y[SAMPLE_W-1:0];
  endfunction

  // Sample driver: hold the beat while stalled, idle in bursts after an accept
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_in_i <= '0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        void'(sample_queue.pop_front());
        if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 6);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_valid_i <= 1'b1;
          sample_in_i <= sample_queue[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result receiver stalls in random bursts while idle_on is set
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Track register writes, predict accepted samples, check delivered results
  always @(posedge clk_i) begin : monitor
    filt_result_t               want;
    logic signed [SAMPLE_W-1:0] y_pred;
    logic                       clip_pred;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) begin
        filter_step(sample_in_i, y_pred, clip_pred);
        expected_out.push_back('{sample: y_pred, clip: clip_pred});
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_out.size() == 0) begin
          report_mismatch("result with none expected", sample_out_o, 0);
        end else begin
          want = expected_out.pop_front();
          if (sample_out_o !== want.sample)
            report_mismatch("sample_out", sample_out_o, want.sample);
          if (saturated_o !== want.clip)
            report_mismatch("saturated", saturated_o, want.clip);
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_taps(input logic [COEF_W-1:0] b0, b1, b2, b3, a1, a2, a3);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_B3, b3);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(REG_A3, a3);
  endtask

  // Wait until every sample is in and every result is out, then let the block settle
  task automatic drain();
    while (sample_queue.size() != 0 || expected_out.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [COEF_W-1:0] pick_coef(input int span);
    if (span == 0) return COEF_W'($urandom());
    return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? SAMPLE_W'(Y_MAX) : SAMPLE_W'(Y_MIN);
      1, 2:    return SAMPLE_W'(int'($urandom_range(0, 510)) - 255);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: order 2, unity b0, all other taps zero
    sample_queue = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, 16'shffff,
                     16'sh5555, 16'shaaaa};
    drain();

    // Gain only, b0 = 0.5: halves round up; other taps must have no effect
    write_reg(REG_ORDER, '0);
    write_taps(COEF_HALF, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    sample_queue = '{16'sh0001, 16'shffff, 16'sh0003, 16'shfffd};
    drain();

    // Full-scale gain saturates both ways; order bits above the field and
    // indexes past the register list are ignored
    write_reg(REG_B0, COEF_MAX);
    write_reg(REG_UNUSED_LO, COEF_ONE);
    write_reg(REG_UNUSED_HI, COEF_MAX);
    write_reg(REG_ORDER, {{(COEF_W-ORDER_W){1'b1}}, 2'd0});
    sample_queue = '{16'sh7fff, 16'sh8000, 16'sh1388};
    drain();

    // Third order with extreme taps
    write_reg(REG_ORDER, COEF_W'(3));
    write_taps(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX);
    sample_queue = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000};
    drain();

    // Drop to first order, then raise again: upper stages must start clean
    write_reg(REG_ORDER, COEF_W'(1));
    write_taps(COEF_ONE, COEF_ONE, '0, COEF_ONE, '0, '0, '0);
    sample_queue = '{16'sh0064, 16'sh00c8};
    drain();
    write_reg(REG_ORDER, COEF_W'(3));
    sample_queue = '{16'sh0000, 16'sh0000, 16'sh0000};
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      int bspan;
      int aspan;
      idle_on = (ph != 3) && (ph != RAND_PHASES - 1);
      bspan = (ph % 2 == 0) ? 16384 : 0;
      aspan = (ph % 2 == 0) ? 4096 : 0;
      write_reg(REG_ORDER, COEF_W'($urandom()));
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 15)), COEF_W'($urandom()));
      write_taps(pick_coef(bspan), pick_coef(bspan), pick_coef(bspan), pick_coef(bspan),
                 pick_coef(aspan), pick_coef(aspan), pick_coef(aspan));
      for (int i = 0; i < PHASE_ITEMS; i++) sample_queue.push_back(pick_sample());
      drain();
    end

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
